### rtl/core/month_grid_generator_top_assert.svh
// Assertion macros used by the month grid generator checker.
`ifndef MONTH_GRID_GENERATOR_TOP_ASSERT_SVH
`define MONTH_GRID_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MGG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("month grid check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MGG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("month grid check failed");

`endif

### rtl/core/mgg_pkg.sv
// Package with types, constants and calendar tables of the month grid generator.
package mgg_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int IDX_W   = 6;

    localparam int GRID_CELLS = 42;
    localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(GRID_CELLS - 1);

    // Reciprocal constants: floor(x * MUL >> SHIFT) equals x / divisor over the used range.
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV7_MUL     = 37450;
    localparam int DIV7_SHIFT   = 18;

    // Bias that keeps the year before the first of the month non-negative.
    localparam int YEAR_BIAS = 400;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_TODAY_YEAR     = 3'd0,
        CFG_TODAY_MONTH    = 3'd1,
        CFG_TODAY_DAY      = 3'd2,
        CFG_SEL_YEAR       = 3'd3,
        CFG_SEL_MONTH      = 3'd4,
        CFG_SEL_DAY        = 3'd5,
        CFG_SEL_PRESENT    = 3'd6
    } t_cfg_addr;

    typedef struct packed {
        logic [YEAR_W-1:0]  today_year;
        logic [MONTH_W-1:0] today_month;
        logic [DAY_W-1:0]   today_day;
        logic [YEAR_W-1:0]  sel_year;
        logic [MONTH_W-1:0] sel_month;
        logic [DAY_W-1:0]   sel_day;
        logic               sel_present;
    } t_cfg;

    // Per-request layout values handed from the month stages to the sequencer.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  prev_year;
        logic [MONTH_W-1:0] prev_mon;
        logic [YEAR_W-1:0]  next_year;
        logic [MONTH_W-1:0] next_mon;
        logic [2:0]         first_wday;
        logic [IDX_W-1:0]   month_end;
        logic [IDX_W-1:0]   prev_base;
    } t_month_params;

    // One finished grid cell.
    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               in_month;
        logic               today_hit;
        logic               sel_hit;
        logic               last;
    } t_cell;

    // Month key of the weekday formula.
    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Length of a month; February grows to 29 days in a leap year.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                          r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:       r = 5'd30;
            default:                       r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/mgg_month_params.sv
// Four-stage pipeline that derives weekday, month lengths and neighbors of a requested month.
module mgg_month_params (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mgg_pkg::YEAR_W-1:0]      i_year,
    input  logic [mgg_pkg::MONTH_W-1:0]     i_month,
    output logic                            o_valid,
    input  logic                            i_ready,
    output mgg_pkg::t_month_params          o_params
);

    logic en1, en2, en3, en4;
    logic r_v1, r_v2, r_v3, r_v4;

    // Stage 1: bias the year and start both divisions by 100.
    logic                        n_s1_month_ok;
    logic                        n_s1_early;
    logic [14:0]                 n_s1_yy;
    logic [26:0]                 n_s1_prod_y;
    logic [26:0]                 n_s1_prod_yy;
    logic [mgg_pkg::YEAR_W-1:0]  r_s1_year;
    logic [mgg_pkg::MONTH_W-1:0] r_s1_month;
    logic [14:0]                 r_s1_yy;
    logic [26:0]                 r_s1_prod_y;
    logic [26:0]                 r_s1_prod_yy;

    // Stage 2: leap year, month lengths and the weekday sum.
    logic [7:0]                  n_s2_qy;
    logic [7:0]                  n_s2_qyy;
    logic [13:0]                 n_s2_rem;
    logic                        n_s2_leap;
    logic [mgg_pkg::MONTH_W-1:0] n_s2_prev_mon;
    logic [14:0]                 n_s2_sum;
    logic [mgg_pkg::YEAR_W-1:0]  r_s2_year;
    logic [mgg_pkg::MONTH_W-1:0] r_s2_month;
    logic [mgg_pkg::DAY_W-1:0]   r_s2_dim;
    logic [mgg_pkg::DAY_W-1:0]   r_s2_pdim;
    logic [14:0]                 r_s2_sum;

    // Stage 3: reciprocal multiply for the weekday modulo 7.
    logic [30:0]                 n_s3_prod7;
    logic [mgg_pkg::YEAR_W-1:0]  r_s3_year;
    logic [mgg_pkg::MONTH_W-1:0] r_s3_month;
    logic [mgg_pkg::DAY_W-1:0]   r_s3_dim;
    logic [mgg_pkg::DAY_W-1:0]   r_s3_pdim;
    logic [14:0]                 r_s3_sum;
    logic [30:0]                 r_s3_prod7;

    // Stage 4: weekday and the layout boundaries.
    logic [12:0]                 n_s4_q7;
    logic [2:0]                  n_s4_wday;
    mgg_pkg::t_month_params      n_s4_params;
    mgg_pkg::t_month_params      r_s4_params;

    // A stage takes new data when it is empty or its content moves on.
    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid && n_s1_month_ok;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Requests with a month outside January..December produce no grid.
    assign n_s1_month_ok = (i_month >= mgg_pkg::MONTH_JAN) && (i_month <= mgg_pkg::MONTH_DEC);
    assign n_s1_early    = (i_month < mgg_pkg::MONTH_MAR);
    assign n_s1_yy       = 15'(i_year) + 15'(mgg_pkg::YEAR_BIAS) - {14'd0, n_s1_early};
    assign n_s1_prod_y   = 27'(i_year) * 27'(mgg_pkg::DIV100_MUL);
    assign n_s1_prod_yy  = 27'(n_s1_yy) * 27'(mgg_pkg::DIV100_MUL);

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_year    <= i_year;
            r_s1_month   <= i_month;
            r_s1_yy      <= n_s1_yy;
            r_s1_prod_y  <= n_s1_prod_y;
            r_s1_prod_yy <= n_s1_prod_yy;
        end
    end

    // Leap rule from the quotient and remainder by 100.
    assign n_s2_qy   = r_s1_prod_y[26:mgg_pkg::DIV100_SHIFT];
    assign n_s2_qyy  = r_s1_prod_yy[26:mgg_pkg::DIV100_SHIFT];
    assign n_s2_rem  = r_s1_year - 14'(14'(n_s2_qy) * 14'd100);
    assign n_s2_leap = (r_s1_year[1:0] == 2'b00)
                    && ((n_s2_rem != 14'd0) || (n_s2_qy[1:0] == 2'b00));
    assign n_s2_prev_mon = (r_s1_month == mgg_pkg::MONTH_JAN) ? mgg_pkg::MONTH_DEC
                                                              : r_s1_month - 4'd1;
    // The previous month shares the leap flag whenever it is February.
    assign n_s2_sum  = r_s1_yy + {2'b00, r_s1_yy[14:2]} - 15'(n_s2_qyy) + 15'(n_s2_qyy[7:2])
                     + 15'(mgg_pkg::month_offset(r_s1_month)) + 15'd1;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_year  <= r_s1_year;
            r_s2_month <= r_s1_month;
            r_s2_dim   <= mgg_pkg::month_days(r_s1_month, n_s2_leap);
            r_s2_pdim  <= mgg_pkg::month_days(n_s2_prev_mon, n_s2_leap);
            r_s2_sum   <= n_s2_sum;
        end
    end

    assign n_s3_prod7 = 31'(r_s2_sum) * 31'(mgg_pkg::DIV7_MUL);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_year  <= r_s2_year;
            r_s3_month <= r_s2_month;
            r_s3_dim   <= r_s2_dim;
            r_s3_pdim  <= r_s2_pdim;
            r_s3_sum   <= r_s2_sum;
            r_s3_prod7 <= n_s3_prod7;
        end
    end

    // Weekday of the first, then where each part of the grid begins.
    always_comb begin
        n_s4_q7   = r_s3_prod7[30:mgg_pkg::DIV7_SHIFT];
        n_s4_wday = 3'(r_s3_sum - 15'(15'(n_s4_q7) * 15'd7));
        n_s4_params.year       = r_s3_year;
        n_s4_params.month      = r_s3_month;
        n_s4_params.prev_year  = (r_s3_month == mgg_pkg::MONTH_JAN) ? r_s3_year - 14'd1
                                                                    : r_s3_year;
        n_s4_params.prev_mon   = (r_s3_month == mgg_pkg::MONTH_JAN) ? mgg_pkg::MONTH_DEC
                                                                    : r_s3_month - 4'd1;
        n_s4_params.next_year  = (r_s3_month == mgg_pkg::MONTH_DEC) ? r_s3_year + 14'd1
                                                                    : r_s3_year;
        n_s4_params.next_mon   = (r_s3_month == mgg_pkg::MONTH_DEC) ? mgg_pkg::MONTH_JAN
                                                                    : r_s3_month + 4'd1;
        n_s4_params.first_wday = n_s4_wday;
        n_s4_params.month_end  = 6'(n_s4_wday) + 6'(r_s3_dim);
        n_s4_params.prev_base  = 6'(r_s3_pdim) - 6'(n_s4_wday) + 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_params <= n_s4_params;
        end
    end

    assign o_valid  = r_v4;
    assign o_params = r_s4_params;

endmodule

### rtl/core/mgg_cell_seq.sv
// Sequencer that holds one month layout and steps the cell index from 0 to 41.
module mgg_cell_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  mgg_pkg::t_month_params          i_params,
    output logic                            o_valid,
    input  logic                            i_ready,
    output mgg_pkg::t_month_params          o_params,
    output logic [mgg_pkg::IDX_W-1:0]       o_idx
);

    logic                        r_busy;
    logic                        n_busy;
    logic [mgg_pkg::IDX_W-1:0]   r_idx;
    logic [mgg_pkg::IDX_W-1:0]   n_idx;
    mgg_pkg::t_month_params      r_params;
    logic                        at_last;
    logic                        take;

    assign at_last = (r_idx == mgg_pkg::LAST_CELL);
    // A new layout loads while the last cell of the previous one leaves.
    assign o_ready = !r_busy || (i_ready && at_last);
    assign take    = o_ready && i_valid;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (take) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (r_busy && i_ready) begin
            n_busy = !at_last;
            n_idx  = r_idx + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_params <= i_params;
        end
    end

    assign o_valid  = r_busy;
    assign o_params = r_params;
    assign o_idx    = r_idx;

endmodule

### rtl/core/mgg_cell_fmt.sv
// Two-stage cell formatter: date of the cell, then today and selection flags into the output register.
module mgg_cell_fmt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  mgg_pkg::t_month_params          i_params,
    input  logic [mgg_pkg::IDX_W-1:0]       i_idx,
    input  mgg_pkg::t_cfg                   i_cfg,
    output logic                            o_valid,
    input  logic                            i_ready,
    output mgg_pkg::t_cell                  o_cell
);

    logic           en_out, en1;
    logic           r_v1, r_v2;
    mgg_pkg::t_cell n_s1_cell;
    mgg_pkg::t_cell r_s1_cell;
    mgg_pkg::t_cell n_s2_cell;
    mgg_pkg::t_cell r_s2_cell;

    assign en_out  = !r_v2 || i_ready;
    assign en1     = !r_v1 || en_out;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en_out) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Pick the previous, current or next month by the cell position.
    always_comb begin
        n_s1_cell       = '0;
        n_s1_cell.index = i_idx;
        n_s1_cell.last  = (i_idx == mgg_pkg::LAST_CELL);
        if (i_idx < 6'(i_params.first_wday)) begin
            n_s1_cell.year  = i_params.prev_year;
            n_s1_cell.month = i_params.prev_mon;
            n_s1_cell.day   = 5'(i_params.prev_base + i_idx);
        end else if (i_idx < i_params.month_end) begin
            n_s1_cell.year     = i_params.year;
            n_s1_cell.month    = i_params.month;
            n_s1_cell.day      = 5'(i_idx - 6'(i_params.first_wday) + 6'd1);
            n_s1_cell.in_month = 1'b1;
        end else begin
            n_s1_cell.year  = i_params.next_year;
            n_s1_cell.month = i_params.next_mon;
            n_s1_cell.day   = 5'(i_idx - i_params.month_end + 6'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_cell <= n_s1_cell;
        end
    end

    // Compare the cell date with today and with the selection.
    always_comb begin
        n_s2_cell = r_s1_cell;
        n_s2_cell.today_hit = (r_s1_cell.year == i_cfg.today_year)
                           && (r_s1_cell.month == i_cfg.today_month)
                           && (r_s1_cell.day == i_cfg.today_day);
        n_s2_cell.sel_hit = i_cfg.sel_present
                         && (r_s1_cell.year == i_cfg.sel_year)
                         && (r_s1_cell.month == i_cfg.sel_month)
                         && (r_s1_cell.day == i_cfg.sel_day);
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_s2_cell <= n_s2_cell;
        end
    end

    assign o_valid = r_v2;
    assign o_cell  = r_s2_cell;

endmodule

### rtl/core/month_grid_generator_top.sv
// Top level of the month grid generator: configuration registers, stream ports and pipeline.
//
//  channel   direction  accepted when                        payload
//  s_axis    in         i_s_axis_tvalid & o_s_axis_tready    year, month of the grid
//  m_axis    out        o_m_axis_tvalid & i_m_axis_tready    one grid cell per word
//  cfg       in         i_cfg_we                             register i_cfg_addr
//
// Each request yields 42 output words, one per cycle while the output is ready; the cell
// sequencer sets that rate, so in steady state a request is taken as each grid completes.
// The first cell passes seven register stages before it is offered: 4 month stages,
// the sequencer, the date stage and the output register.
// A stalled output freezes the stages behind it; nothing is lost or repeated.
// Synchronous active-low reset empties the stages; today is 2000-01-01, no selection.
module month_grid_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request: [13:0] grid_year, [17:14] grid_month, [23:18] zero.
    input  logic [23:0] i_s_axis_tdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Cell: [5:0] cell_index, [19:6] cell_year, [23:20] cell_month, [28:24] cell_day,
    // [31:29] zero.
    output logic [31:0] o_m_axis_tdata,
    // Flags: [0] in_month, [1] today flag, [2] selection flag.
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [13:0] i_cfg_wdata
);

    mgg_pkg::t_cfg          r_cfg;
    mgg_pkg::t_month_params prm_params;
    logic                   prm_valid;
    logic                   seq_ready;
    mgg_pkg::t_month_params seq_params;
    logic [mgg_pkg::IDX_W-1:0] seq_idx;
    logic                   seq_valid;
    logic                   fmt_ready;
    mgg_pkg::t_cell         fmt_cell;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.today_year  <= 14'd2000;
            r_cfg.today_month <= 4'd1;
            r_cfg.today_day   <= 5'd1;
            r_cfg.sel_year    <= 14'd0;
            r_cfg.sel_month   <= 4'd1;
            r_cfg.sel_day     <= 5'd1;
            r_cfg.sel_present <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mgg_pkg::CFG_TODAY_YEAR:  r_cfg.today_year  <= i_cfg_wdata;
                mgg_pkg::CFG_TODAY_MONTH: r_cfg.today_month <= i_cfg_wdata[3:0];
                mgg_pkg::CFG_TODAY_DAY:   r_cfg.today_day   <= i_cfg_wdata[4:0];
                mgg_pkg::CFG_SEL_YEAR:    r_cfg.sel_year    <= i_cfg_wdata;
                mgg_pkg::CFG_SEL_MONTH:   r_cfg.sel_month   <= i_cfg_wdata[3:0];
                mgg_pkg::CFG_SEL_DAY:     r_cfg.sel_day     <= i_cfg_wdata[4:0];
                mgg_pkg::CFG_SEL_PRESENT: r_cfg.sel_present <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Month stages: weekday of the first and the month lengths.
    mgg_month_params u_params (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_year   (i_s_axis_tdata[13:0]),
        .i_month  (i_s_axis_tdata[17:14]),
        .o_valid  (prm_valid),
        .i_ready  (seq_ready),
        .o_params (prm_params)
    );

    // Cell sequencer: walks the 42 grid positions of one layout.
    mgg_cell_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (prm_valid),
        .o_ready  (seq_ready),
        .i_params (prm_params),
        .o_valid  (seq_valid),
        .i_ready  (fmt_ready),
        .o_params (seq_params),
        .o_idx    (seq_idx)
    );

    // Cell formatter and output register.
    mgg_cell_fmt u_fmt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (seq_valid),
        .o_ready  (fmt_ready),
        .i_params (seq_params),
        .i_idx    (seq_idx),
        .i_cfg    (r_cfg),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_cell   (fmt_cell)
    );

    assign o_m_axis_tdata = {3'b000, fmt_cell.day, fmt_cell.month, fmt_cell.year,
                             fmt_cell.index};
    assign o_m_axis_tuser = {fmt_cell.sel_hit, fmt_cell.today_hit, fmt_cell.in_month};
    assign o_m_axis_tlast = fmt_cell.last;

endmodule

### rtl/core/mgg_checker.sv
// Port-level checker of the month grid generator and its bind to the top level.
`include "month_grid_generator_top_assert.svh"

module mgg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] o_m_axis_tdata,
    input  logic [2:0]  o_m_axis_tuser,
    input  logic        o_m_axis_tlast,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready
);

    logic out_stall;
    logic first_in_month;

    assign out_stall      = o_m_axis_tvalid && !i_m_axis_tready;
    assign first_in_month = o_m_axis_tvalid && (o_m_axis_tdata[5:0] == 6'd0)
                         && o_m_axis_tuser[0];

    // A stalled word stays offered and unchanged.
    `MGG_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, out_stall,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // The closing word of a grid sits at position 41.
    `MGG_ASSERT_NOW(a_last_index, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast,
        o_m_axis_tdata[5:0] == 6'd41)

    // The last cell always falls in the next month.
    `MGG_ASSERT_NOW(a_last_outside, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast,
        !o_m_axis_tuser[0])

    // A month that starts on Sunday shows its first day in the first cell.
    `MGG_ASSERT_NOW(a_sunday_start, i_clk, i_rst_n, first_in_month,
        o_m_axis_tdata[28:24] == 5'd1)

endmodule

bind month_grid_generator_top mgg_checker u_mgg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

### tb/testbench.sv
// Self-checking testbench of the month grid generator: calendar edges, flags, stalls, random.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LENGTH  = 400;
    localparam int CONFIG_CHUNK  = 40;

    // Index past the last register; the block must drop writes to it.
    localparam logic [2:0] CFG_NO_REG = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [23:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [13:0] i_cfg_wdata = '0;

    // Copy of the date registers as they stand after reset.
    mgg_pkg::t_cfg date_regs = '{today_year: 14'd2000, today_month: 4'd1, today_day: 5'd1,
                                 sel_year: 14'd0, sel_month: 4'd1, sel_day: 5'd1,
                                 sel_present: 1'b0};

    mgg_pkg::t_cell pending_cells[$];
    int    mismatch_count = 0;
    int    cycle_count = 0;
    int    sender_idle_pct = 0;
    int    receiver_idle_pct = 0;
    int    stall_cycles = 0;

    month_grid_generator_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output side: random idling, or a long hold-off while stall_cycles runs down.
    always @(posedge i_clk) begin
        if (stall_cycles > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_cycles = stall_cycles - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        if (m == 2) begin
            return leap_year(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    // Zeller's congruence for the first of the month, remapped so that 0 is Sunday.
    // The 400-year bias keeps the year before March of year 0 positive.
    function automatic int unsigned weekday_of_first(input int unsigned y, input int unsigned m);
        int unsigned yz;
        int unsigned mz;
        int unsigned h;
        yz = y + 400 - ((m < 3) ? 1 : 0);
        mz = (m < 3) ? m + 12 : m;
        h = (1 + (13 * (mz + 1)) / 5 + yz + yz / 4 - yz / 100 + yz / 400) % 7;
        return (h + 6) % 7;
    endfunction

    // Lays out the 42 cells of one request and queues them; bad months yield nothing.
    function automatic void build_month_grid(input logic [mgg_pkg::YEAR_W-1:0] year_in,
                                             input logic [mgg_pkg::MONTH_W-1:0] month_in);
        int unsigned y, m, py, pm, ny, nm, w, dim, pdim, cy, cm, cd;
        mgg_pkg::t_cell c;
        y = year_in;
        m = month_in;
        if (m < 1 || m > 12) begin
            return;
        end
        py = (m == 1) ? ((y - 1) & 32'h3FFF) : y;
        pm = (m == 1) ? 12 : m - 1;
        ny = (m == 12) ? ((y + 1) & 32'h3FFF) : y;
        nm = (m == 12) ? 1 : m + 1;
        w = weekday_of_first(y, m);
        dim = month_length(y, m);
        pdim = month_length(py, pm);
        for (int unsigned i = 0; i < mgg_pkg::GRID_CELLS; i++) begin
            if (i < w) begin
                cy = py; cm = pm; cd = pdim - w + 1 + i;
            end else if (i < w + dim) begin
                cy = y; cm = m; cd = i - w + 1;
            end else begin
                cy = ny; cm = nm; cd = i - w - dim + 1;
            end
            c.index     = mgg_pkg::IDX_W'(i);
            c.year      = mgg_pkg::YEAR_W'(cy);
            c.month     = mgg_pkg::MONTH_W'(cm);
            c.day       = mgg_pkg::DAY_W'(cd);
            c.in_month  = (i >= w) && (i < w + dim);
            c.today_hit = (c.year == date_regs.today_year) &&
                          (c.month == date_regs.today_month) &&
                          (c.day == date_regs.today_day);
            c.sel_hit   = date_regs.sel_present && (c.year == date_regs.sel_year) &&
                          (c.month == date_regs.sel_month) && (c.day == date_regs.sel_day);
            c.last      = (i == mgg_pkg::GRID_CELLS - 1);
            pending_cells.insert(pending_cells.size(), c);
        end
    endfunction

    task automatic check_field(input string what, input int unsigned pos,
                               input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: cell %0d %s expected %0d, got %0d", $time, pos, what, want, got);
            mismatch_count++;
        end
    endtask

    // Compares every accepted output word with the oldest queued cell.
    always @(posedge i_clk) begin
        mgg_pkg::t_cell got;
        mgg_pkg::t_cell want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.index     = o_m_axis_tdata[5:0];
            got.year      = o_m_axis_tdata[19:6];
            got.month     = o_m_axis_tdata[23:20];
            got.day       = o_m_axis_tdata[28:24];
            got.in_month  = o_m_axis_tuser[0];
            got.today_hit = o_m_axis_tuser[1];
            got.sel_hit   = o_m_axis_tuser[2];
            got.last      = o_m_axis_tlast;
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected cell %0d, date %0d-%0d-%0d", $time,
                         got.index, got.year, got.month, got.day);
                mismatch_count++;
            end else begin
                want = pending_cells.pop_front();
                check_field("cell_index", want.index, want.index, got.index);
                check_field("cell_year", want.index, want.year, got.year);
                check_field("cell_month", want.index, want.month, got.month);
                check_field("cell_day", want.index, want.day, got.day);
                check_field("in_month", want.index, want.in_month, got.in_month);
                check_field("today flag", want.index, want.today_hit, got.today_hit);
                check_field("selection flag", want.index, want.sel_hit, got.sel_hit);
                check_field("last_cell", want.index, want.last, got.last);
            end
        end
    end

    // Offers one request word and waits for it to be taken.
    task automatic send_request(input logic [mgg_pkg::YEAR_W-1:0] year,
                                input logic [mgg_pkg::MONTH_W-1:0] month);
        // An occasional pause; its length moves the next offer across the grid phases.
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
        end
        i_s_axis_tdata  <= {6'd0, month, year};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        build_month_grid(year, month);
    endtask

    // Stops offering and waits until every queued cell has come out and the pipe is empty.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [13:0] value);
        logic [13:0] junk;
        logic [13:0] data;
        junk = ($urandom_range(3) == 0) ? 14'($urandom) : 14'd0;
        data = value;
        // Narrow registers sometimes get junk above their width; only the low bits count.
        case (addr)
            mgg_pkg::CFG_TODAY_YEAR: date_regs.today_year = value;
            mgg_pkg::CFG_TODAY_MONTH: begin
                date_regs.today_month = value[3:0];
                data[13:4] = junk[13:4];
            end
            mgg_pkg::CFG_TODAY_DAY: begin
                date_regs.today_day = value[4:0];
                data[13:5] = junk[13:5];
            end
            mgg_pkg::CFG_SEL_YEAR: date_regs.sel_year = value;
            mgg_pkg::CFG_SEL_MONTH: begin
                date_regs.sel_month = value[3:0];
                data[13:4] = junk[13:4];
            end
            mgg_pkg::CFG_SEL_DAY: begin
                date_regs.sel_day = value[4:0];
                data[13:5] = junk[13:5];
            end
            mgg_pkg::CFG_SEL_PRESENT: begin
                date_regs.sel_present = value[0];
                data[13:1] = junk[13:1];
            end
            default: ;
        endcase
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // Writes all date registers, plus one write to the unused index, with the block idle.
    task automatic program_config(input mgg_pkg::t_cfg c);
        drain_results();
        write_reg(mgg_pkg::CFG_TODAY_YEAR, c.today_year);
        write_reg(mgg_pkg::CFG_TODAY_MONTH, 14'(c.today_month));
        write_reg(mgg_pkg::CFG_TODAY_DAY, 14'(c.today_day));
        write_reg(mgg_pkg::CFG_SEL_YEAR, c.sel_year);
        write_reg(mgg_pkg::CFG_SEL_MONTH, 14'(c.sel_month));
        write_reg(mgg_pkg::CFG_SEL_DAY, 14'(c.sel_day));
        write_reg(mgg_pkg::CFG_SEL_PRESENT, 14'(c.sel_present));
        write_reg(CFG_NO_REG, 14'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Mostly plausible dates, now and then any register value.
    function automatic mgg_pkg::t_cfg random_config();
        mgg_pkg::t_cfg c;
        c.today_year  = ($urandom_range(7) == 0) ? 14'($urandom) : 14'($urandom_range(1, 9998));
        c.today_month = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
        c.today_day   = ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 31));
        c.sel_year    = $urandom_range(1) ? c.today_year : 14'($urandom);
        c.sel_month   = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
        c.sel_day     = ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 31));
        c.sel_present = ($urandom_range(3) != 0);
        return c;
    endfunction

    // Random requests clustered around the configured dates so the flags fire.
    task automatic send_random_requests(input int count);
        int sent;
        int pick;
        logic [mgg_pkg::YEAR_W-1:0] y;
        logic [mgg_pkg::MONTH_W-1:0] m;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            m = 4'($urandom_range(1, 12));
            if (pick < 6) begin
                y = 14'($urandom);
                m = 4'($urandom);
            end else if (pick < 25) begin
                y = 14'($urandom);
            end else if (pick < 60) begin
                y = date_regs.today_year + 14'($urandom_range(2)) - 14'd1;
            end else if (pick < 80) begin
                y = date_regs.sel_year + 14'($urandom_range(2)) - 14'd1;
            end else begin
                y = 14'($urandom_range(1, 9998));
            end
            send_request(y, m);
            if (m >= 1 && m <= 12) begin
                sent++;
            end
        end
    endtask

    // Registers at their reset values: Jan 1 2000 is today, the idle selection never shows.
    task automatic test_reset_defaults();
        send_request(14'd2000, 4'd1);
        send_request(14'd0, 4'd1);
    endtask

    // Year wrap, leap rules, grids that start on Sunday or need all six rows, bad months.
    task automatic test_calendar_edges();
        send_request(14'd16383, 4'd12);
        send_request(14'd0, 4'd2);
        send_request(14'd1, 4'd1);
        send_request(14'd9998, 4'd12);
        send_request(14'd1900, 4'd2);
        send_request(14'd2000, 4'd2);
        send_request(14'd2023, 4'd2);
        send_request(14'd2100, 4'd2);
        send_request(14'd2015, 4'd2);
        send_request(14'd2020, 4'd8);
        send_request(14'd2024, 4'd4);
        send_request(14'd2024, 4'd7);
        send_request(14'd2024, 4'd9);
        send_request(14'd2024, 4'd10);
        send_request(14'd2024, 4'd11);
        send_request(14'd5461, 4'd6);
        send_request(14'd10922, 4'd5);
        send_request(14'd2024, 4'd0);
        send_request(14'd2024, 4'd13);
        send_request(14'd16383, 4'd15);
    endtask

    // Today and selection placed in leading, current and trailing cells, and out of range.
    task automatic test_today_and_selection();
        program_config('{today_year: 14'd2024, today_month: 4'd2, today_day: 5'd29,
                         sel_year: 14'd2024, sel_month: 4'd4, sel_day: 5'd6, sel_present: 1'b1});
        send_request(14'd2024, 4'd3);
        program_config('{today_year: 14'd2024, today_month: 4'd3, today_day: 5'd15,
                         sel_year: 14'd2024, sel_month: 4'd3, sel_day: 5'd15, sel_present: 1'b1});
        send_request(14'd2024, 4'd3);
        program_config('{today_year: 14'd2024, today_month: 4'd3, today_day: 5'd15,
                         sel_year: 14'd2024, sel_month: 4'd3, sel_day: 5'd15, sel_present: 1'b0});
        send_request(14'd2024, 4'd3);
        program_config('{today_year: 14'd16383, today_month: 4'd12, today_day: 5'd31,
                         sel_year: 14'd0, sel_month: 4'd1, sel_day: 5'd1, sel_present: 1'b1});
        send_request(14'd16383, 4'd12);
        program_config('{today_year: 14'd0, today_month: 4'd15, today_day: 5'd31,
                         sel_year: 14'd16383, sel_month: 4'd0, sel_day: 5'd0, sel_present: 1'b1});
        send_request(14'd0, 4'd1);
    endtask

    // Output held off for a long stretch while requests keep coming, then a full pause.
    task automatic test_output_stall();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        program_config(random_config());
        stall_cycles = STALL_LENGTH;
        send_random_requests(20);
        drain_results();
        send_random_requests(4);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int items);
        sender_idle_pct = tx_pct;
        receiver_idle_pct = rx_pct;
        for (int done = 0; done < items; done += CONFIG_CHUNK) begin
            program_config(random_config());
            send_random_requests(CONFIG_CHUNK);
        end
    endtask

    initial begin
        sender_idle_pct = 9;
        receiver_idle_pct = 46;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_calendar_edges();
        test_today_and_selection();
        test_output_stall();
        test_random_traffic(9, 46, 160);
        test_random_traffic(46, 9, 160);
        test_random_traffic(0, 0, 160);
        drain_results();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
